// File: src/spq_pkg.sv
// Shared constants, codes and types of the stable priority queue.
`default_nettype none

package spq_pkg;

  localparam int unsigned CapacityDef = 64;
  localparam int unsigned IdBitsDef   = 16;

  localparam int unsigned KindWidth   = 2;
  localparam int unsigned IdWidth     = 16;
  localparam int unsigned PrioWidth   = 4;
  localparam int unsigned StatusWidth = 2;

  typedef enum logic [KindWidth-1:0] {
    KIND_INSERT = 2'd0,
    KIND_POP    = 2'd1,
    KIND_SEARCH = 2'd2,
    KIND_DELETE = 2'd3
  } kind_e;

  typedef enum logic [StatusWidth-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // latch the accepted beat
    logic compare; // evaluate all cells against the key
    logic commit;  // update the cells and load the result register
  } dp_cmd_t;

endpackage

`default_nettype wire

// File: src/spq_if.sv
// Valid/ready channel interfaces for the queue requests and results.
`default_nettype none

interface spq_in_if;
  logic                          valid;
  logic                          ready;
  logic [spq_pkg::KindWidth-1:0] kind;
  logic [spq_pkg::IdWidth-1:0]   entry_id;
  logic [spq_pkg::PrioWidth-1:0] prio;

  modport source (output valid, output kind, output entry_id, output prio, input ready);
  modport sink   (input valid, input kind, input entry_id, input prio, output ready);
endinterface

interface spq_out_if #(
  parameter int unsigned OCC_W = 7
);
  logic                            valid;
  logic                            ready;
  logic [spq_pkg::StatusWidth-1:0] status;
  logic [spq_pkg::IdWidth-1:0]     out_id;
  logic [spq_pkg::PrioWidth-1:0]   out_prio;
  logic [OCC_W-1:0]                occupancy;

  modport source (output valid, output status, output out_id, output out_prio,
                  output occupancy, input ready);
  modport sink   (input valid, input status, input out_id, input out_prio,
                  input occupancy, output ready);
endinterface

`default_nettype wire

// File: src/stable_priority_queue.sv
// Top level of the stable priority queue: controller plus cell datapath.
//
//   channel | modport       | beat payload
//   in_i    | spq_in_if     | kind, entry_id, prio
//   out_o   | spq_out_if    | status, out_id, out_prio, occupancy
//
// Each beat is latched when accepted, then takes a compare step, which checks every
// cell against the key in parallel, and an update step, which shifts the cells and
// loads the result register. A new beat may be taken in the update step. Reset clears
// only the fill count and control state; cells are not cleared but written before use.
// A result not taken holds the block in its update cycle; input is stalled until then.
`default_nettype none

module stable_priority_queue #(
  parameter int unsigned CAPACITY = spq_pkg::CapacityDef,
  parameter int unsigned ID_BITS  = spq_pkg::IdBitsDef
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  spq_in_if.sink     in_i,
  spq_out_if.source  out_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  spq_pkg::dp_cmd_t cmd;
  logic             in_ready;
  logic             out_valid;
  logic [CntW-1:0]  res_occ;

  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  spq_datapath #(
    .CAPACITY (CAPACITY),
    .ID_BITS  (ID_BITS),
    .CNT_W    (CntW)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .in_kind_i    (in_i.kind),
    .in_id_i      (in_i.entry_id),
    .in_prio_i    (in_i.prio),
    .res_status_o (out_o.status),
    .res_id_o     (out_o.out_id),
    .res_prio_o   (out_o.out_prio),
    .res_occ_o    (res_occ)
  );

  assign in_i.ready      = in_ready;
  assign out_o.valid     = out_valid;
  assign out_o.occupancy = res_occ;

endmodule

`default_nettype wire

// File: src/spq_ctrl.sv
// Controller: handshakes, sequencing and the result valid flag.
`default_nettype none

module spq_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output spq_pkg::dp_cmd_t     cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_UPD  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  logic   fire;
  logic   commit;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) || ((state_q == S_UPD) && out_free);
  assign fire       = in_valid_i && in_ready_o;
  assign commit     = (state_q == S_UPD) && out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (fire) state_d = S_CMP;
      end
      S_CMP: begin
        state_d = S_UPD;
      end
      S_UPD: begin
        // hold here while the previous result has not been taken
        if (out_free) state_d = fire ? S_CMP : S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign cmd_o.load     = fire;
  assign cmd_o.compare  = (state_q == S_CMP);
  assign cmd_o.commit   = commit;

  a_cmp_to_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP) |=> (state_q == S_UPD))
    else $error("compare step not followed by update step");

  a_overlap_commits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (state_q == S_UPD)) |-> cmd_o.commit)
    else $error("beat accepted during update without commit");

  a_commit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> out_valid_o)
    else $error("committed result not presented");

endmodule

`default_nettype wire

// File: src/spq_datapath.sv
// Datapath: row of sorted cells, parallel compares, shifts and result register.
`default_nettype none

module spq_datapath #(
  parameter int unsigned CAPACITY = spq_pkg::CapacityDef,
  parameter int unsigned ID_BITS  = spq_pkg::IdBitsDef,
  parameter int unsigned CNT_W    = $clog2(CAPACITY + 1)
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire spq_pkg::dp_cmd_t                cmd_i,
  input  wire logic [spq_pkg::KindWidth-1:0]   in_kind_i,
  input  wire logic [spq_pkg::IdWidth-1:0]     in_id_i,
  input  wire logic [spq_pkg::PrioWidth-1:0]   in_prio_i,
  output logic [spq_pkg::StatusWidth-1:0]      res_status_o,
  output logic [spq_pkg::IdWidth-1:0]          res_id_o,
  output logic [spq_pkg::PrioWidth-1:0]        res_prio_o,
  output logic [CNT_W-1:0]                     res_occ_o
);

  localparam int unsigned SidW = (ID_BITS < spq_pkg::IdWidth) ? ID_BITS : spq_pkg::IdWidth;

  // Latched request
  spq_pkg::kind_e                op_q;
  logic [SidW-1:0]               key_id_q;
  logic [spq_pkg::PrioWidth-1:0] key_prio_q;

  // Cells, in service order
  logic [SidW-1:0]               id_q   [CAPACITY];
  logic [spq_pkg::PrioWidth-1:0] prio_q [CAPACITY];
  logic [CNT_W-1:0]              count_q, count_d;

  // Per-cell neighbors and flags
  logic [SidW-1:0]               up_id   [CAPACITY];
  logic [spq_pkg::PrioWidth-1:0] up_prio [CAPACITY];
  logic [SidW-1:0]               dn_id   [CAPACITY];
  logic [spq_pkg::PrioWidth-1:0] dn_prio [CAPACITY];
  logic [CAPACITY-1:0]           valid;
  logic [CAPACITY-1:0]           le_q;
  logic [CAPACITY-1:0]           match_q;
  logic [CAPACITY-1:0]           prev_le;
  logic [CAPACITY-1:0]           hit_le;
  logic [CAPACITY-1:0]           first_hit;
  logic [CAPACITY-1:0]           take_new;
  logic [CAPACITY-1:0]           take_prev;
  logic [CAPACITY-1:0]           take_next;

  logic                          full;
  logic                          empty;
  logic                          found;
  logic [SidW-1:0]               sel_id;
  logic [spq_pkg::PrioWidth-1:0] sel_prio;

  // Result register
  spq_pkg::status_e              res_status_q, res_status_d;
  logic [SidW-1:0]               res_id_q, res_id_d;
  logic [spq_pkg::PrioWidth-1:0] res_prio_q, res_prio_d;
  logic [CNT_W-1:0]              res_occ_q;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    assign valid[g] = (CNT_W'(g) < count_q);
    if (g == 0) begin : g_head
      assign up_id[g]   = key_id_q;
      assign up_prio[g] = key_prio_q;
      assign prev_le[g] = 1'b1;
    end else begin : g_body
      assign up_id[g]   = id_q[g-1];
      assign up_prio[g] = prio_q[g-1];
      assign prev_le[g] = le_q[g-1];
    end
    if (g == CAPACITY - 1) begin : g_tail
      assign dn_id[g]   = id_q[g];
      assign dn_prio[g] = prio_q[g];
    end else begin : g_inner
      assign dn_id[g]   = id_q[g+1];
      assign dn_prio[g] = prio_q[g+1];
    end
  end

  assign full  = (count_q == CNT_W'(CAPACITY));
  assign empty = (count_q == '0);

  // First-match position: prefix OR over the registered match flags
  always_comb begin
    hit_le[0] = match_q[0];
    for (int i = 1; i < CAPACITY; i++) begin
      hit_le[i] = hit_le[i-1] | match_q[i];
    end
    first_hit = match_q & ~{hit_le[CAPACITY-2:0], 1'b0};
  end

  assign found = hit_le[CAPACITY-1];

  always_comb begin
    sel_id   = '0;
    sel_prio = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      sel_id   = sel_id   | (id_q[i]   & {SidW{first_hit[i]}});
      sel_prio = sel_prio | (prio_q[i] & {spq_pkg::PrioWidth{first_hit[i]}});
    end
  end

  // Cell moves on commit
  always_comb begin
    take_new  = '0;
    take_prev = '0;
    take_next = '0;
    if (cmd_i.commit) begin
      case (op_q)
        spq_pkg::KIND_INSERT: begin
          if (!full) begin
            // cells past the last not-greater entry open a slot and shift up
            take_new  = ~le_q & prev_le;
            take_prev = ~le_q & ~prev_le;
          end
        end
        spq_pkg::KIND_POP: begin
          if (!empty) take_next = '1;
        end
        spq_pkg::KIND_DELETE: begin
          take_next = hit_le;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    count_d      = count_q;
    res_status_d = spq_pkg::ST_OK;
    res_id_d     = '0;
    res_prio_d   = '0;
    case (op_q)
      spq_pkg::KIND_INSERT: begin
        if (full) begin
          res_status_d = spq_pkg::ST_FULL;
        end else begin
          count_d = count_q + 1'b1;
        end
      end
      spq_pkg::KIND_POP: begin
        if (empty) begin
          res_status_d = spq_pkg::ST_MISS;
        end else begin
          res_id_d   = id_q[0];
          res_prio_d = prio_q[0];
          count_d    = count_q - 1'b1;
        end
      end
      spq_pkg::KIND_SEARCH: begin
        if (found) begin
          res_id_d   = sel_id;
          res_prio_d = sel_prio;
        end else begin
          res_status_d = spq_pkg::ST_MISS;
        end
      end
      default: begin
        if (found) begin
          count_d = count_q - 1'b1;
        end else begin
          res_status_d = spq_pkg::ST_MISS;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.commit) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q       <= spq_pkg::kind_e'(in_kind_i);
      key_id_q   <= in_id_i[SidW-1:0];
      key_prio_q <= in_prio_i;
    end
    if (cmd_i.compare) begin
      for (int i = 0; i < CAPACITY; i++) begin
        le_q[i]    <= valid[i] && (prio_q[i] <= key_prio_q);
        match_q[i] <= valid[i] && (id_q[i] == key_id_q);
      end
    end
    for (int i = 0; i < CAPACITY; i++) begin
      if (take_new[i]) begin
        id_q[i]   <= key_id_q;
        prio_q[i] <= key_prio_q;
      end else if (take_prev[i]) begin
        id_q[i]   <= up_id[i];
        prio_q[i] <= up_prio[i];
      end else if (take_next[i]) begin
        id_q[i]   <= dn_id[i];
        prio_q[i] <= dn_prio[i];
      end
    end
    if (cmd_i.commit) begin
      res_status_q <= res_status_d;
      res_id_q     <= res_id_d;
      res_prio_q   <= res_prio_d;
      res_occ_q    <= count_d;
    end
  end

  assign res_status_o = res_status_q;
  assign res_id_o     = spq_pkg::IdWidth'(res_id_q);
  assign res_prio_o   = res_prio_q;
  assign res_occ_o    = res_occ_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("fill count beyond capacity");

  a_pop_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && (op_q == spq_pkg::KIND_POP) && (count_q != '0))
      |=> (count_q == CNT_W'($past(count_q) - 1'b1)))
    else $error("pop did not release one entry");

  a_single_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> $onehot0(first_hit))
    else $error("more than one first match");

endmodule

`default_nettype wire
